FILE: hdl/prvu_pkg.sv
// Shared types, constants and CORDIC angle table for the polar/rectangular vector unit.
package prvu_pkg;

  // CORDIC iteration count and angle table
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_W       = $clog2(TABLE_LEN);

  // divider quotient width (result magnitude width)
  localparam int QUO_W = 25;

  // CORDIC datapath width (6 fraction bits plus growth headroom)
  localparam int CW = 34;

  // reciprocal of the limit gain of the CORDIC, Q30
  localparam logic [29:0] GAIN = 30'd652032874;

  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;

  // arctangent of 2^-i in 1/2^32 turn
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [2:0] {
    OP_TO_POLAR = 3'd0,
    OP_TO_RECT  = 3'd1,
    OP_ADD      = 3'd2,
    OP_SUB      = 3'd3,
    OP_MUL      = 3'd4,
    OP_DIV      = 3'd5
  } opcode_t;

  // word travelling through the divider chain
  typedef struct packed {
    logic [2:0]         op;
    logic signed [24:0] rx;
    logic signed [24:0] ry;
    logic [23:0]        amag;
    logic [15:0]        abrg;
    logic [39:0]        prod;
    logic [15:0]        sc;
    logic [15:0]        rem;
    logic [QUO_W-1:0]   n_lo;
    logic [QUO_W-1:0]   quo;
    logic               ovf;
  } div_t;

  // word travelling through the CORDIC chain
  typedef struct packed {
    logic                 vec;   // vectoring (to polar) when set, rotation otherwise
    logic                 zero;  // zero input vector
    logic                 nul;   // all-zero result
    logic                 dz;    // divide by zero
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] z;
    logic signed [24:0]   rx;
    logic signed [24:0]   ry;
    logic [24:0]          mag;
    logic [15:0]          brg;
  } crd_t;

endpackage

FILE: hdl/prvu_if.sv
// Request and response channel interfaces of the vector unit.
interface prvu_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [23:0] a_x;
  logic signed [23:0] a_y;
  logic [23:0]        a_mag;
  logic [15:0]        a_bearing;
  logic signed [23:0] b_x;
  logic signed [23:0] b_y;
  logic [15:0]        scalar;

  modport source(output valid, opcode, a_x, a_y, a_mag, a_bearing, b_x, b_y, scalar,
                 input ready);
  modport sink(input valid, opcode, a_x, a_y, a_mag, a_bearing, b_x, b_y, scalar,
               output ready);
endinterface

interface prvu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] x;
  logic signed [24:0] y;
  logic [24:0]        mag;
  logic [15:0]        bearing;
  logic               div_zero;

  modport source(output valid, x, y, mag, bearing, div_zero, input ready);
  modport sink(input valid, x, y, mag, bearing, div_zero, output ready);
endinterface

FILE: hdl/prvu_div_cell.sv
// One restoring-division cell: develops one quotient bit per stage.
module prvu_div_cell import prvu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  div_t din,
  output logic vout,
  output div_t dout
);

  logic [16:0] trial;
  logic        take;
  div_t        dout_next;

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    trial     = {din.rem, din.n_lo[QUO_W-1]};
    take      = trial >= {1'b0, din.sc};
    dout_next = din;
    dout_next.rem  = take ? 16'(trial - {1'b0, din.sc}) : trial[15:0];
    dout_next.n_lo = {din.n_lo[QUO_W-2:0], 1'b0};
    dout_next.quo  = {din.quo[QUO_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: hdl/prvu_cordic_cell.sv
// One CORDIC micro-rotation cell, vectoring or rotation mode per word.
module prvu_cordic_cell import prvu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  logic              vin,
  input  crd_t              din,
  output logic              vout,
  output crd_t              dout
);

  logic signed [CW-1:0] du;
  logic signed [CW-1:0] dv;
  logic signed [CW-1:0] ang;
  logic                 pos;
  crd_t                 dout_next;

  // direction: vectoring drives v to zero, rotation drives z to zero
  always_comb begin
    du  = din.v >>> step;
    dv  = din.u >>> step;
    ang = $signed({2'b00, ATAN_TAB[step]});
    pos = din.vec ? (din.v[CW-1] || (din.v == '0)) : !din.z[CW-1];
    dout_next = din;
    if (pos) begin
      dout_next.u = din.u - du;
      dout_next.v = din.v + dv;
      dout_next.z = din.z - ang;
    end else begin
      dout_next.u = din.u + du;
      dout_next.v = din.v - dv;
      dout_next.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: hdl/polar_rect_vector_unit.sv
// Vector unit: takes one word per clock while the response is not stalled and returns one
// result word for each, in order. A word passes through the input register, a 25-cell
// restoring divider chain, a gain-multiply stage, a CORDIC setup stage, a chain of
// CORDIC_STEPS (16) micro-rotation cells, a gain/rounding stage and the output register.
// Every opcode takes the same path, so results never reorder.
// A stalled response holds the whole pipeline; req.ready follows rsp.ready in that case.
// Bearing 0 points along +y and grows clockwise; x = mag*sin, y = mag*cos.
module polar_rect_vector_unit import prvu_pkg::*; (
  input logic       clk,
  input logic       rst,
  prvu_req_if.sink  req,
  prvu_rsp_if.source rsp
);

  logic en;

  // ---------------- input stage ----------------
  logic signed [24:0] ax;
  logic signed [24:0] ay;
  logic signed [24:0] bx;
  logic signed [24:0] by;
  logic [32:0]        num;
  div_t               d_in;

  div_t dchain [QUO_W+1];
  logic dval   [QUO_W+1];

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // operand sums, multiply product, divider seed
  always_comb begin
    ax  = {req.a_x[23], req.a_x};
    ay  = {req.a_y[23], req.a_y};
    bx  = {req.b_x[23], req.b_x};
    by  = {req.b_y[23], req.b_y};
    num = {1'b0, req.a_mag, 8'b0} + {18'b0, req.scalar[15:1]};
    d_in.op   = req.opcode;
    d_in.amag = req.a_mag;
    d_in.abrg = req.a_bearing;
    d_in.prod = 40'(req.a_mag) * 40'(req.scalar);
    d_in.sc   = req.scalar;
    d_in.rem  = {8'b0, num[32:25]};
    d_in.n_lo = num[24:0];
    d_in.quo  = '0;
    d_in.ovf  = {8'b0, num[32:25]} >= req.scalar;
    unique case (req.opcode)
      OP_ADD: begin
        d_in.rx = ax + bx;
        d_in.ry = ay + by;
      end
      OP_SUB: begin
        d_in.rx = ax - bx;
        d_in.ry = ay - by;
      end
      default: begin
        d_in.rx = ax;
        d_in.ry = ay;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dval[0] <= 1'b0;
    end else if (en) begin
      dval[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dchain[0] <= d_in;
    end
  end

  // ---------------- divider chain ----------------
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    prvu_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (dval[k]),
      .din  (dchain[k]),
      .vout (dval[k+1]),
      .dout (dchain[k+1])
    );
  end

  // ---------------- magnitude select and gain multiply ----------------
  div_t        dq;
  logic [32:0] mulr;
  logic [24:0] pmag;
  logic        pvec;
  logic        pnul;
  logic        pdz;

  logic               p_val;
  logic               p_vec;
  logic               p_zero;
  logic               p_nul;
  logic               p_dz;
  logic signed [24:0] p_rx;
  logic signed [24:0] p_ry;
  logic [24:0]        p_mag;
  logic [15:0]        p_brg;
  logic [54:0]        p_prod;

  always_comb begin
    dq   = dchain[QUO_W];
    mulr = 33'((41'(dq.prod) + 41'd128) >> 8);
    pmag = '0;
    pvec = 1'b0;
    pnul = 1'b0;
    pdz  = 1'b0;
    unique case (dq.op)
      OP_TO_POLAR, OP_ADD, OP_SUB: pvec = 1'b1;
      OP_TO_RECT: pmag = {1'b0, dq.amag};
      OP_MUL: pmag = (mulr[32:25] != '0) ? '1 : mulr[24:0];
      OP_DIV: begin
        if (dq.sc == '0) begin
          pnul = 1'b1;
          pdz  = 1'b1;
        end else begin
          pmag = dq.ovf ? '1 : dq.quo;
        end
      end
      default: pnul = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_val <= 1'b0;
    end else if (en) begin
      p_val <= dval[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_vec  <= pvec;
      p_zero <= (dq.rx == '0) && (dq.ry == '0);
      p_nul  <= pnul;
      p_dz   <= pdz;
      p_rx   <= dq.rx;
      p_ry   <= dq.ry;
      p_mag  <= pmag;
      p_brg  <= dq.abrg;
      p_prod <= 55'(pmag) * 55'(GAIN);
    end
  end

  // ---------------- CORDIC setup: prerotation and quadrant fold ----------------
  logic [31:0]          u0;
  logic signed [CW-1:0] zr;
  logic signed [CW-1:0] up;
  logic signed [CW-1:0] vp;
  crd_t                 s_next;

  crd_t cchain [CORDIC_STEPS+1];
  logic cval   [CORDIC_STEPS+1];

  always_comb begin
    u0 = 32'((56'(p_prod) + 56'd8388608) >> 24);
    zr = {{2{p_brg[15]}}, p_brg, 16'b0};
    up = {{3{p_ry[24]}}, p_ry, 6'b0};
    vp = {{3{p_rx[24]}}, p_rx, 6'b0};
    s_next.vec  = p_vec;
    s_next.zero = p_zero;
    s_next.nul  = p_nul;
    s_next.dz   = p_dz;
    s_next.rx   = p_rx;
    s_next.ry   = p_ry;
    s_next.mag  = p_mag;
    s_next.brg  = p_brg;
    if (p_vec) begin
      // left half plane: flip and start at half a turn
      if (up[CW-1]) begin
        s_next.u = -up;
        s_next.v = -vp;
        s_next.z = HALF_TURN;
      end else begin
        s_next.u = up;
        s_next.v = vp;
        s_next.z = '0;
      end
    end else begin
      s_next.v = '0;
      if (zr > QUARTER_TURN) begin
        s_next.u = -$signed({2'b00, u0});
        s_next.z = zr - HALF_TURN;
      end else if (zr < -QUARTER_TURN) begin
        s_next.u = -$signed({2'b00, u0});
        s_next.z = zr + HALF_TURN;
      end else begin
        s_next.u = $signed({2'b00, u0});
        s_next.z = zr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cval[0] <= 1'b0;
    end else if (en) begin
      cval[0] <= p_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cchain[0] <= s_next;
    end
  end

  // ---------------- CORDIC chain ----------------
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    prvu_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .step (STEP_W'(k)),
      .vin  (cval[k]),
      .din  (cchain[k]),
      .vout (cval[k+1]),
      .dout (cchain[k+1])
    );
  end

  // ---------------- gain multiply and rounding shift ----------------
  crd_t        cq;
  logic [32:0] umag;
  logic [31:0] zrnd;

  logic               f_val;
  logic               f_vec;
  logic               f_zero;
  logic               f_nul;
  logic               f_dz;
  logic signed [24:0] f_rx;
  logic signed [24:0] f_ry;
  logic [24:0]        f_mag;
  logic [15:0]        f_brg;
  logic [15:0]        f_zb;
  logic [62:0]        f_mprod;
  logic signed [28:0] f_xr;
  logic signed [28:0] f_yr;

  always_comb begin
    cq   = cchain[CORDIC_STEPS];
    umag = cq.u[CW-1] ? '0 : cq.u[32:0];
    zrnd = cq.z[31:0] + 32'h8000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_val <= 1'b0;
    end else if (en) begin
      f_val <= cval[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_vec   <= cq.vec;
      f_zero  <= cq.zero;
      f_nul   <= cq.nul;
      f_dz    <= cq.dz;
      f_rx    <= cq.rx;
      f_ry    <= cq.ry;
      f_mag   <= cq.mag;
      f_brg   <= cq.brg;
      f_zb    <= zrnd[31:16];
      f_mprod <= 63'(umag) * 63'(GAIN);
      f_xr    <= 29'(($signed({cq.v[CW-1], cq.v}) + 35'sd32) >>> 6);
      f_yr    <= 29'(($signed({cq.u[CW-1], cq.u}) + 35'sd32) >>> 6);
    end
  end

  // ---------------- output register ----------------
  logic [27:0]        mraw;
  logic [24:0]        mcor;
  logic signed [24:0] xs;
  logic signed [24:0] ys;

  // saturate a 29-bit signed value to 25 bits
  function automatic logic signed [24:0] sat_s25(input logic signed [28:0] a);
    logic signed [28:0] hi;
    logic signed [28:0] lo;
    hi = 29'sd16777215;
    lo = -29'sd16777216;
    if (a > hi) begin
      return 25'sd16777215;
    end else if (a < lo) begin
      return -25'sd16777216;
    end
    return a[24:0];
  endfunction

  always_comb begin
    mraw = 28'((64'(f_mprod) + 64'h8_0000_0000) >> 36);
    mcor = (mraw[27:25] != '0) ? '1 : mraw[24:0];
    xs   = sat_s25(f_xr);
    ys   = sat_s25(f_yr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= f_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.div_zero <= f_dz;
      if (f_nul) begin
        rsp.x       <= '0;
        rsp.y       <= '0;
        rsp.mag     <= '0;
        rsp.bearing <= '0;
      end else if (f_vec) begin
        rsp.x       <= f_rx;
        rsp.y       <= f_ry;
        rsp.mag     <= f_zero ? '0 : mcor;
        rsp.bearing <= f_zero ? '0 : f_zb;
      end else begin
        rsp.x       <= xs;
        rsp.y       <= ys;
        rsp.mag     <= f_mag;
        rsp.bearing <= f_brg;
      end
    end
  end

  // ---------------- checks ----------------
  // divide by zero always comes back as an all-zero word
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.div_zero |->
      rsp.x == '0 && rsp.y == '0 && rsp.mag == '0 && rsp.bearing == '0)
    else $error("div_zero word carries nonzero fields");

  // vectoring starts in the right half plane
  a_vec_start: assert property (@(posedge clk) disable iff (rst)
    cval[0] && cchain[0].vec |-> !cchain[0].u[CW-1])
    else $error("vectoring seed has negative u");

  // rotation angle folded into plus/minus a quarter turn
  a_rot_fold: assert property (@(posedge clk) disable iff (rst)
    cval[0] && !cchain[0].vec |->
      $signed(cchain[0].z) <= QUARTER_TURN && $signed(cchain[0].z) >= -QUARTER_TURN)
    else $error("rotation angle outside folded range");

  // nothing comes out the cycle after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid && !f_val && !cval[0])
    else $error("pipeline not empty after reset");

endmodule
